// ===== hdl/itp_pkg.sv =====
// itp_pkg: shared constants, types and helper functions for the infix-to-postfix converter.
// No dependencies. Used by itp_ctrl, itp_datapath and infix_to_postfix_converter.
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    // ASCII codes of the special characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    // Operator codes held on the stack
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_OPEN = 3'd1;
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_MUL  = 3'd4;
    localparam logic [2:0] OP_DIV  = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CLOSE    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_OPEN     = 2'd3;

    // Controller -> datapath
    typedef struct packed {
        logic       load;       // latch the input transfer
        logic       emit_char;  // emit the latched character
        logic       emit_top;   // emit the operator on top of the stack
        logic       pop;
        logic       push;       // push the operator of the latched character
        logic [1:0] set_err;    // error to record, ERR_NONE for none
        logic       finish;     // send the closing result, clear the stack
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [2:0] ch_op;      // operator code of latched character
        logic       is_space;
        logic       is_close;
        logic       end_flag;
        logic [2:0] top_op;
        logic       empty;
        logic       emit_ok;    // an emission can be taken this cycle
        logic       out_free;   // output register can be loaded this cycle
    } status_t;

    function automatic logic [2:0] op_of_char(input logic [7:0] ch);
        logic [2:0] op;
        op = OP_NONE;
        case (ch)
            CH_OPEN: op = OP_OPEN;
            CH_ADD:  op = OP_ADD;
            CH_SUB:  op = OP_SUB;
            CH_MUL:  op = OP_MUL;
            CH_DIV:  op = OP_DIV;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] char_of_op(input logic [2:0] op);
        logic [7:0] ch;
        ch = 8'h00;
        case (op)
            OP_OPEN: ch = CH_OPEN;
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            OP_MUL:  ch = CH_MUL;
            OP_DIV:  ch = CH_DIV;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] rank_of(input logic [2:0] op);
        logic [1:0] r;
        r = 2'd0;
        case (op)
            OP_MUL, OP_DIV: r = 2'd2;
            OP_ADD, OP_SUB: r = 2'd1;
            default:        r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/itp_ram.sv =====
// itp_ram: generic single-write, single-read RAM with registered read.
// Write-first on an address collision. No dependencies.
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/itp_ctrl.sv =====
// itp_ctrl: sequencing state machine of the converter (decode, pop loops, flush, close).
// Depends on itp_pkg; drives itp_datapath through itp_pkg::cmd_t.
module itp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  itp_pkg::status_t  st,
    output itp_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROC  = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_OPPOP = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] after_st;
    logic       top_is_open;
    logic       op_stops;

    assign after_st    = st.end_flag ? S_FLUSH : S_IDLE;
    assign top_is_open = (st.top_op == itp_pkg::OP_OPEN);
    // incoming operator stops popping at '(' or a lower-ranked operator
    assign op_stops    = st.empty || top_is_open ||
                         (itp_pkg::rank_of(st.ch_op) > itp_pkg::rank_of(st.top_op));

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC: begin
                if (st.is_space) begin
                    state_next = after_st;
                end else if (st.is_close) begin
                    state_next = S_CLOSE;
                end else if (st.ch_op == itp_pkg::OP_OPEN) begin
                    cmd.push   = 1'b1;
                    state_next = after_st;
                end else if (st.ch_op != itp_pkg::OP_NONE) begin
                    state_next = S_OPPOP;
                end else if (st.emit_ok) begin
                    cmd.emit_char = 1'b1;
                    state_next    = after_st;
                end
            end
            S_CLOSE: begin
                if (st.empty) begin
                    cmd.set_err = itp_pkg::ERR_CLOSE;
                    state_next  = after_st;
                end else if (top_is_open) begin
                    cmd.pop    = 1'b1;
                    state_next = after_st;
                end else if (st.emit_ok) begin
                    cmd.emit_top = 1'b1;
                    cmd.pop      = 1'b1;
                end
            end
            S_OPPOP: begin
                if (op_stops) begin
                    cmd.push   = 1'b1;
                    state_next = after_st;
                end else if (st.emit_ok) begin
                    cmd.emit_top = 1'b1;
                    cmd.pop      = 1'b1;
                end
            end
            S_FLUSH: begin
                if (st.empty) begin
                    state_next = S_FIN;
                end else if (top_is_open) begin
                    cmd.set_err = itp_pkg::ERR_OPEN;
                    cmd.pop     = 1'b1;
                end else if (st.emit_ok) begin
                    cmd.emit_top = 1'b1;
                    cmd.pop      = 1'b1;
                end
            end
            S_FIN: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== hdl/itp_datapath.sv =====
// itp_datapath: input latch, operator stack (itp_ram + count), sticky error,
// hold register for the final symbol and the output register. Depends on itp_pkg, itp_ram.
module itp_datapath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  itp_pkg::cmd_t     cmd,
    output itp_pkg::status_t  st,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [2:0]        m_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]    ch_reg;
    logic          end_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    err_reg, err_next;
    logic          hold_valid_reg, hold_valid_next;
    logic [7:0]    hold_sym_reg, hold_sym_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_sym_reg, m_sym_next;
    logic          m_has_reg, m_has_next;
    logic          m_last_reg, m_last_next;
    logic [1:0]    m_err_reg, m_err_next;

    logic          full;
    logic          out_free;
    logic          emit;
    logic [7:0]    emit_sym;
    logic [1:0]    new_err;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [2:0]    top_op;
    logic [2:0]    ch_op;

    assign ch_op    = itp_pkg::op_of_char(ch_reg);
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = cmd.emit_char || cmd.emit_top;
    assign emit_sym = cmd.emit_char ? ch_reg : itp_pkg::char_of_op(top_op);
    assign wr_en    = cmd.push && !full;

    // overflow is detected here; the controller only asks for the push
    assign new_err  = (cmd.push && full) ? itp_pkg::ERR_OVERFLOW : cmd.set_err;

    always_comb begin
        count_next = count_reg;
        if (cmd.finish) begin
            count_next = '0;
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
        end else if (wr_en) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb begin
        err_next = err_reg;
        if (cmd.finish) begin
            err_next = itp_pkg::ERR_NONE;
        end else if (err_reg == itp_pkg::ERR_NONE) begin
            err_next = new_err;
        end
    end

    // read address tracks the top after this cycle's update
    assign rd_addr = count_next[AW-1:0] - AW'(1);

    itp_ram #(
        .WIDTH (3),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (ch_op),
        .raddr (rd_addr),
        .rdata (top_op)
    );

    always_comb begin
        m_valid_next    = out_free ? 1'b0 : m_valid_reg;
        m_sym_next      = m_sym_reg;
        m_has_next      = m_has_reg;
        m_last_next     = m_last_reg;
        m_err_next      = m_err_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        if (cmd.finish) begin
            m_valid_next    = 1'b1;
            m_sym_next      = hold_valid_reg ? hold_sym_reg : 8'h00;
            m_has_next      = hold_valid_reg;
            m_last_next     = 1'b1;
            m_err_next      = err_reg;
            hold_valid_next = 1'b0;
        end else if (emit) begin
            if (end_reg) begin
                // final expression item: keep the newest symbol back for tlast
                hold_sym_next   = emit_sym;
                hold_valid_next = 1'b1;
                if (hold_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = hold_sym_reg;
                    m_has_next   = 1'b1;
                    m_last_next  = 1'b0;
                    m_err_next   = itp_pkg::ERR_NONE;
                end
            end else begin
                m_valid_next = 1'b1;
                m_sym_next   = emit_sym;
                m_has_next   = 1'b1;
                m_last_next  = 1'b0;
                m_err_next   = itp_pkg::ERR_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_reg        <= 1'b0;
            count_reg      <= '0;
            err_reg        <= itp_pkg::ERR_NONE;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                end_reg <= s_tlast;
            end
            count_reg      <= count_next;
            err_reg        <= err_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg <= s_tdata;
        end
        hold_sym_reg <= hold_sym_next;
        m_sym_reg    <= m_sym_next;
        m_has_reg    <= m_has_next;
        m_last_reg   <= m_last_next;
        m_err_reg    <= m_err_next;
    end

    always_comb begin
        st.ch_op    = ch_op;
        st.is_space = (ch_reg == itp_pkg::CH_SPACE);
        st.is_close = (ch_reg == itp_pkg::CH_CLOSE);
        st.end_flag = end_reg;
        st.top_op   = top_op;
        st.empty    = (count_reg == '0);
        st.emit_ok  = (end_reg && !hold_valid_reg) || out_free;
        st.out_free = out_free;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sym_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_err_reg, m_has_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_hold_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> end_reg)
        else $error("held symbol outside final item");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (count_reg == '0) && (err_reg == itp_pkg::ERR_NONE) && !hold_valid_reg)
        else $error("expression state not cleared after close");

    a_bare_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_has_reg) |-> m_last_reg)
        else $error("bare marker without tlast");

    a_err_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_err_reg == itp_pkg::ERR_NONE))
        else $error("error code on a non-final result");

endmodule

// ===== hdl/infix_to_postfix_converter.sv =====
// infix_to_postfix_converter: top level of the shunting-yard infix-to-postfix converter.
// Depends on itp_pkg, itp_ctrl, itp_datapath (which holds itp_ram).
//
// Takes one ASCII character per input transfer and produces the postfix form, one
// character per output transfer. Spaces are skipped, ( ) + - * / are operators and
// everything else is an operand passed straight through. The input transfer with
// s_tlast set closes the expression: the operator stack is flushed and the final
// output transfer carries m_tlast plus the first error seen (m_tuser[2:1]: 0 none,
// 1 unmatched ')', 2 stack overflow, 3 unmatched '('); if that final character made
// no symbol, a bare marker with m_tuser[0] = 0 is sent. One character is handled at
// a time. An operand, a space or a '(' is taken in an accept state, then decoded.
// An operator is decoded, pops stack entries down to a '(' or a lower-ranked one
// and is then pushed; a ')' is decoded and pops operators on the way to its '('.
// An end-of-expression transfer then flushes the stack and sends the closing
// transfer. The pop loop through the stack RAM handles one entry per cycle while
// no output back-pressure holds it. Output back-pressure holds the loop only when
// a symbol or the closing transfer is ready and the output register is still full.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF  // 2 .. 62
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic       s_tlast,   // end of expression
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] symbol
    output logic       m_tlast,   // final result of the expression
    output logic [2:0] m_tuser    // [0] has_symbol, [2:1] error
);

    itp_pkg::cmd_t    cmd;
    itp_pkg::status_t st;

    // sequencer: owns s_tready, steps the pop/flush loops
    itp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // stack, error tracking and output register
    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/sv/infix_to_postfix_converter_test.sv =====
// Self-checking testbench for infix_to_postfix_converter: drives character streams,
// predicts the postfix transfers and compares each one field by field.
// Depends on itp_pkg and the converter RTL.
`timescale 1ns / 1ps

module infix_to_postfix_converter_test;

    localparam int DEPTH            = itp_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT      = 1_000_000;  // far beyond the slowest legal run
    localparam int LONG_HOLD_CYCLES = 300;        // sink back-pressure stretch
    localparam int DRAIN_CYCLES     = 3 * DEPTH;  // worst flush plus closing transfer

    // stack glyph for each operator code
    localparam logic [7:0] OP_GLYPH [0:7] =
        '{8'h00, itp_pkg::CH_OPEN, itp_pkg::CH_ADD, itp_pkg::CH_SUB,
          itp_pkg::CH_MUL, itp_pkg::CH_DIV, 8'h00, 8'h00};
    localparam logic [7:0] ARITH_CHARS [0:3] =
        '{itp_pkg::CH_ADD, itp_pkg::CH_SUB, itp_pkg::CH_MUL, itp_pkg::CH_DIV};

    // one expected output transfer
    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       last;
        logic [1:0] error;
    } postfix_item_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] character
    logic       s_tlast  = 1'b0;    // end of expression
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] symbol
    logic       m_tlast;
    logic [2:0] m_tuser;            // [0] has_symbol, [2:1] error

    // shadow of the operator stack and sticky error
    logic [2:0]    shadow_stack [DEPTH];
    int            shadow_depth = 0;
    logic [1:0]    shadow_error = itp_pkg::ERR_NONE;
    postfix_item_t expected_postfix [$];

    int failures      = 0;
    int chars_sent    = 0;   // non-space characters accepted
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int long_hold_req = 0;   // bumped by the test to request a sink hold-off
    int long_hold_seen = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    infix_to_postfix_converter #(.STACK_DEPTH(DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Postfix predictor
    // ---------------------------------------------------------------------
    function automatic logic [2:0] operator_code(input logic [7:0] ch);
        case (ch)
            itp_pkg::CH_OPEN: return itp_pkg::OP_OPEN;
            itp_pkg::CH_ADD:  return itp_pkg::OP_ADD;
            itp_pkg::CH_SUB:  return itp_pkg::OP_SUB;
            itp_pkg::CH_MUL:  return itp_pkg::OP_MUL;
            itp_pkg::CH_DIV:  return itp_pkg::OP_DIV;
            default:          return itp_pkg::OP_NONE;
        endcase
    endfunction

    // multiply and divide bind tighter than add and subtract
    function automatic int precedence(input logic [2:0] op);
        return (op == itp_pkg::OP_MUL || op == itp_pkg::OP_DIV) ? 2 : 1;
    endfunction

    function automatic void queue_symbol(input logic [7:0] sym);
        expected_postfix.push_back('{sym, 1'b1, 1'b0, itp_pkg::ERR_NONE});
    endfunction

    // only the first error of an expression is kept
    function automatic void note_error(input logic [1:0] code);
        if (shadow_error == itp_pkg::ERR_NONE)
            shadow_error = code;
    endfunction

    function automatic void predict_postfix(input logic [7:0] ch, input logic eoe);
        logic [2:0] op;
        logic [2:0] top_op;
        bit         matched;
        int         mark;
        op   = operator_code(ch);
        mark = expected_postfix.size();
        if (ch == itp_pkg::CH_SPACE) begin
            // skipped
        end else if (ch == itp_pkg::CH_CLOSE) begin
            // unwind to the matching open paren, emitting operators on the way
            matched = 1'b0;
            while (shadow_depth > 0 && !matched) begin
                shadow_depth--;
                top_op = shadow_stack[shadow_depth];
                if (top_op == itp_pkg::OP_OPEN)
                    matched = 1'b1;
                else
                    queue_symbol(OP_GLYPH[top_op]);
            end
            if (!matched)
                note_error(itp_pkg::ERR_CLOSE);
        end else if (op == itp_pkg::OP_NONE) begin
            queue_symbol(ch);
        end else begin
            if (op != itp_pkg::OP_OPEN) begin
                while (shadow_depth > 0 &&
                       shadow_stack[shadow_depth - 1] != itp_pkg::OP_OPEN &&
                       precedence(shadow_stack[shadow_depth - 1]) >= precedence(op)) begin
                    shadow_depth--;
                    queue_symbol(OP_GLYPH[shadow_stack[shadow_depth]]);
                end
            end
            // a push onto a full stack is dropped
            if (shadow_depth >= DEPTH) begin
                note_error(itp_pkg::ERR_OVERFLOW);
            end else begin
                shadow_stack[shadow_depth] = op;
                shadow_depth++;
            end
        end
        if (eoe) begin
            // flush: operators go out, leftover open parens are dropped and flagged
            while (shadow_depth > 0) begin
                shadow_depth--;
                top_op = shadow_stack[shadow_depth];
                if (top_op == itp_pkg::OP_OPEN)
                    note_error(itp_pkg::ERR_OPEN);
                else
                    queue_symbol(OP_GLYPH[top_op]);
            end
            // nothing emitted by this character: a bare end marker closes the expression
            if (expected_postfix.size() == mark)
                expected_postfix.push_back('{8'h00, 1'b0, 1'b0, itp_pkg::ERR_NONE});
            expected_postfix[expected_postfix.size() - 1].last  = 1'b1;
            expected_postfix[expected_postfix.size() - 1].error = shadow_error;
            shadow_error = itp_pkg::ERR_NONE;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request, checking
    // ---------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        postfix_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_postfix.size() == 0) begin
                $error("unexpected transfer: symbol %h, tlast %b, tuser %h",
                       m_tdata, m_tlast, m_tuser);
                failures++;
            end else begin
                want = expected_postfix.pop_front();
                compare_field("symbol", want.symbol, m_tdata);
                compare_field("has_symbol", {7'd0, want.has_symbol}, {7'd0, m_tuser[0]});
                compare_field("last", {7'd0, want.last}, {7'd0, m_tlast});
                compare_field("error", {6'd0, want.error}, {6'd0, m_tuser[2:1]});
            end
        end
        if (long_hold_req != long_hold_seen) begin
            long_hold_seen = long_hold_req;
            hold_left      = LONG_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------
    // Offer one character, with random idle cycles ahead of it; predict once accepted.
    task automatic send_char(input logic [7:0] ch, input logic eoe);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eoe;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_postfix(ch, eoe);
        if (ch != itp_pkg::CH_SPACE)
            chars_sent++;
    endtask

    // whole expression, tlast on its final character
    task automatic send_text(input logic [7:0] text [$]);
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    function automatic logic [7:0] random_operand();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(255));
        while (ch inside {itp_pkg::CH_SPACE, itp_pkg::CH_OPEN, itp_pkg::CH_CLOSE,
                          itp_pkg::CH_ADD, itp_pkg::CH_SUB, itp_pkg::CH_MUL,
                          itp_pkg::CH_DIV});
        return ch;
    endfunction

    function automatic logic [7:0] random_operator();
        return ARITH_CHARS[$urandom_range(3)];
    endfunction

    task automatic set_idle(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // All four operators, both parens, and the operand extremes 00 and FF.
    task automatic test_operators();
        send_text({itp_pkg::CH_OPEN, 8'h00, itp_pkg::CH_SUB, 8'hFF, itp_pkg::CH_CLOSE,
                   itp_pkg::CH_DIV, 8'h63, itp_pkg::CH_MUL, 8'h64, itp_pkg::CH_ADD,
                   8'h65});
    endtask

    // Unmatched close that still emits its pops, unmatched open, a close then an
    // open (first error wins, bare marker), and a lone space closing cleanly.
    task automatic test_error_codes();
        send_text({8'h61, itp_pkg::CH_ADD, 8'h62, itp_pkg::CH_CLOSE});
        send_text({itp_pkg::CH_OPEN, 8'h71});
        send_text({itp_pkg::CH_CLOSE, itp_pkg::CH_OPEN});
        send_text({itp_pkg::CH_SPACE});
    endtask

    // Fill the stack with "(+" pairs, push one more operator, then flush the lot.
    task automatic test_stack_overflow();
        logic [7:0] text [$];
        text = {};
        repeat (DEPTH / 2) begin
            text.push_back(itp_pkg::CH_OPEN);
            text.push_back(itp_pkg::CH_ADD);
        end
        text.push_back(itp_pkg::CH_MUL);
        text.push_back(8'h79);
        send_text(text);
    endtask

    // Sink holds off for a long stretch while a long chain of random operators and
    // operands keeps arriving, so the converter fills up and drops s_tready.
    task automatic test_output_backpressure();
        logic [7:0] text [$];
        text = {};
        for (int i = 0; i < 21; i++) begin
            if (i != 0)
                text.push_back(random_operator());
            text.push_back(random_operand());
        end
        long_hold_req++;
        send_text(text);
    endtask

    // Mostly well-formed expressions with random content; the rest are raw
    // byte noise, deep nesting that can overflow, or unbalanced parens.
    task automatic send_random_expression();
        logic [7:0] text [$];
        int         style;
        int         terms;
        int         depth;
        int         run;
        style = $urandom_range(19);
        text  = {};
        depth = 0;
        if (style == 0) begin
            repeat ($urandom_range(1, 12))
                send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
            send_char(8'($urandom_range(255)), 1'b1);
        end else if (style == 1) begin
            run = $urandom_range(6, 10);   // 9 levels and up overflow the stack
            repeat (run) begin
                text.push_back(itp_pkg::CH_OPEN);
                text.push_back(random_operand());
                text.push_back(random_operator());
            end
            text.push_back(random_operand());
            repeat ($urandom_range(0, run))
                text.push_back(itp_pkg::CH_CLOSE);
            send_text(text);
        end else begin
            terms = $urandom_range(1, 7);
            for (int i = 0; i < terms; i++) begin
                if (i != 0)
                    text.push_back(random_operator());
                if ($urandom_range(3) == 0) begin
                    run = $urandom_range(1, 2);
                    repeat (run)
                        text.push_back(itp_pkg::CH_OPEN);
                    depth += run;
                end
                if ($urandom_range(9) == 0)
                    text.push_back(itp_pkg::CH_SPACE);
                text.push_back(random_operand());
                if (depth > 0 && $urandom_range(2) == 0) begin
                    run = $urandom_range(1, depth);
                    repeat (run)
                        text.push_back(itp_pkg::CH_CLOSE);
                    depth -= run;
                end
            end
            if (style == 2) begin
                // broken: leave parens open, sometimes add a stray close
                if ($urandom_range(1) == 1)
                    text.push_back(itp_pkg::CH_CLOSE);
            end else begin
                repeat (depth)
                    text.push_back(itp_pkg::CH_CLOSE);
            end
            send_text(text);
        end
    endtask

    task automatic test_random_stream(input int n_chars);
        int start;
        start = chars_sent;
        while (chars_sent - start < n_chars)
            send_random_expression();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender sparse-ish, sink mostly stalled
        set_idle(37, 73);
        test_operators();
        test_error_codes();
        test_stack_overflow();
        test_random_stream(50);

        // sender mostly idle, sink mostly ready
        set_idle(73, 37);
        test_random_stream(50);

        // full rate, then the long sink hold-off
        set_idle(0, 0);
        test_output_backpressure();
        test_random_stream(30);
        s_tvalid <= 1'b0;

        while (expected_postfix.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
